### rtl/core/sdmd_pkg.sv
// Shared types, constants and glyph font for the serial dot-matrix display controller.
// Depends on nothing; the design modules refer to it by scoped names.

package sdmd_pkg;

   // Frame and glyph geometry
   localparam int FRAME_BYTES  = 8;
   localparam int FRAME_IDX_W  = 3;
   localparam int GLYPH_ROWS   = 5;
   localparam int GLYPH_COUNT  = 18;
   localparam int SHIFT_LIMIT  = 20;
   localparam int SCAN_ROWS    = 8;

   // Configuration port
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_HANDSHAKE_ZERO_COUNT = 2'd0;
   localparam logic [1:0] REG_BRIGHTNESS_SPAN      = 2'd1;
   localparam logic [1:0] REG_BRIGHTNESS_BASE      = 2'd2;

   // Register reset values
   localparam logic [7:0]  HZC_RESET   = 8'd6;
   localparam logic [11:0] SPAN_RESET  = 12'd550;
   localparam logic [11:0] BASE_RESET  = 12'd40;

   // State reset values
   localparam logic [11:0] COMPARE_RESET = 12'hFFF;
   localparam logic [7:0]  ROWS_OFF      = 8'hFF;
   localparam logic [7:0]  RAW_ROW_DRIVE = 8'h7F;

   // Input event codes
   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_SCAN    = 2'd1,
      OP_ROW_OFF = 2'd2,
      OP_BRIGHT  = 2'd3
   } opcode_type;

   // Link modes
   typedef enum logic [1:0] {
      MODE_DISC = 2'd0,
      MODE_HAND = 2'd1,
      MODE_DISP = 2'd2
   } mode_type;

   // Classified commands handed from the front end to the back end
   typedef enum logic [2:0] {
      CMD_RX_BYTE  = 3'd0,
      CMD_RX_ERROR = 3'd1,
      CMD_SCAN     = 3'd2,
      CMD_ROW_OFF  = 3'd3,
      CMD_BRIGHT   = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         zero;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [7:0]  handshake_zero_count;
      logic [11:0] brightness_span;
      logic [11:0] brightness_base;
   } cfg_type;

   // Pack five 3-bit glyph rows, top row in the low bits
   function automatic logic [14:0] pack_rows(input logic [2:0] r0, input logic [2:0] r1,
                                             input logic [2:0] r2, input logic [2:0] r3,
                                             input logic [2:0] r4);
      return {r4, r3, r2, r1, r0};
   endfunction

   // Font ROM: 3-wide glyphs, five rows each; unknown codes are blank
   function automatic logic [14:0] glyph_bits(input logic [4:0] code);
      logic [14:0] bits;
      unique case (code)
         5'd0:    bits = pack_rows(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
         5'd1:    bits = pack_rows(3'd6, 3'd2, 3'd2, 3'd2, 3'd7);
         5'd2:    bits = pack_rows(3'd7, 3'd1, 3'd7, 3'd4, 3'd7);
         5'd3:    bits = pack_rows(3'd7, 3'd1, 3'd7, 3'd1, 3'd7);
         5'd4:    bits = pack_rows(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
         5'd5:    bits = pack_rows(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
         5'd6:    bits = pack_rows(3'd7, 3'd4, 3'd7, 3'd5, 3'd7);
         5'd7:    bits = pack_rows(3'd7, 3'd1, 3'd1, 3'd1, 3'd1);
         5'd8:    bits = pack_rows(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
         5'd9:    bits = pack_rows(3'd7, 3'd5, 3'd7, 3'd1, 3'd7);
         5'd10:   bits = pack_rows(3'd1, 3'd1, 3'd1, 3'd1, 3'd1);
         5'd11:   bits = pack_rows(3'd0, 3'd0, 3'd5, 3'd2, 3'd5);
         5'd12:   bits = pack_rows(3'd7, 3'd4, 3'd7, 3'd4, 3'd4);
         5'd13:   bits = pack_rows(3'd7, 3'd4, 3'd4, 3'd4, 3'd7);
         5'd14:   bits = pack_rows(3'd3, 3'd3, 3'd0, 3'd0, 3'd0);
         5'd15:   bits = pack_rows(3'd0, 3'd0, 3'd0, 3'd0, 3'd2);
         5'd16:   bits = pack_rows(3'd0, 3'd2, 3'd0, 3'd2, 3'd0);
         default: bits = '0;
      endcase
      return bits;
   endfunction

endpackage

### rtl/core/sdmd_req_if.sv
// Input event channel: valid/ready handshake carrying one event word.
// Depends on nothing.

interface sdmd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] rx_byte;
   logic       frame_error;

   modport source(output valid, output opcode, output rx_byte, output frame_error,
                  input ready);
   modport sink(input valid, input opcode, input rx_byte, input frame_error,
                output ready);
endinterface

### rtl/core/sdmd_rsp_if.sv
// Result channel: valid/ready handshake carrying the display state after each event.
// Depends on nothing.

interface sdmd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  row_drive;
   logic [15:0] column_drive;
   logic        status_led;
   logic [11:0] row_off_compare;
   logic [1:0]  link_mode;
   logic        link_ready;

   modport source(output valid, output row_drive, output column_drive, output status_led,
                  output row_off_compare, output link_mode, output link_ready,
                  input ready);
   modport sink(input valid, input row_drive, input column_drive, input status_led,
                input row_off_compare, input link_mode, input link_ready,
                output ready);
endinterface

### rtl/core/sdmd_csr.sv
// APB-style configuration registers: zero-byte threshold, brightness span and base.
// Depends on sdmd_pkg.

module sdmd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sdmd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sdmd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sdmd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output sdmd_pkg::cfg_type                 cfg
);

   logic [7:0]  hzc_ff, hzc_in;
   logic [11:0] span_ff, span_in;
   logic [11:0] base_ff, base_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Decode writes; an unknown index leaves everything as it is
   always_comb begin
      hzc_in  = hzc_ff;
      span_in = span_ff;
      base_in = base_ff;
      if (wr_en) begin
         unique case (reg_idx)
            sdmd_pkg::REG_HANDSHAKE_ZERO_COUNT: hzc_in  = csr_pwdata[7:0];
            sdmd_pkg::REG_BRIGHTNESS_SPAN:      span_in = csr_pwdata[11:0];
            sdmd_pkg::REG_BRIGHTNESS_BASE:      base_in = csr_pwdata[11:0];
            default:                            hzc_in  = hzc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hzc_ff  <= sdmd_pkg::HZC_RESET;
         span_ff <= sdmd_pkg::SPAN_RESET;
         base_ff <= sdmd_pkg::BASE_RESET;
      end else begin
         hzc_ff  <= hzc_in;
         span_ff <= span_in;
         base_ff <= base_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_idx)
         sdmd_pkg::REG_HANDSHAKE_ZERO_COUNT: csr_prdata = {24'd0, hzc_ff};
         sdmd_pkg::REG_BRIGHTNESS_SPAN:      csr_prdata = {20'd0, span_ff};
         sdmd_pkg::REG_BRIGHTNESS_BASE:      csr_prdata = {20'd0, base_ff};
         default:                            csr_prdata = '0;
      endcase
   end

   assign cfg.handshake_zero_count = hzc_ff;
   assign cfg.brightness_span      = span_ff;
   assign cfg.brightness_base      = base_ff;

endmodule

### rtl/core/sdmd_front.sv
// Front end: takes event words from the input channel and classifies them into commands.
// Depends on sdmd_pkg and sdmd_req_if.

module sdmd_front (
   sdmd_req_if.sink                   req_chan,
   input  sdmd_pkg::queue_status_type q_status,
   output logic                       push,
   output sdmd_pkg::cmd_type          push_cmd
);

   // Accept whenever the command queue has room
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

   // Classify the event; a framing error overrides the byte itself
   always_comb begin
      push_cmd.data = req_chan.rx_byte;
      push_cmd.zero = (req_chan.rx_byte == 8'd0);
      unique case (sdmd_pkg::opcode_type'(req_chan.opcode))
         sdmd_pkg::OP_RX_BYTE: push_cmd.kind = req_chan.frame_error ? sdmd_pkg::CMD_RX_ERROR
                                                                    : sdmd_pkg::CMD_RX_BYTE;
         sdmd_pkg::OP_SCAN:    push_cmd.kind = sdmd_pkg::CMD_SCAN;
         sdmd_pkg::OP_ROW_OFF: push_cmd.kind = sdmd_pkg::CMD_ROW_OFF;
         sdmd_pkg::OP_BRIGHT:  push_cmd.kind = sdmd_pkg::CMD_BRIGHT;
         default:              push_cmd.kind = sdmd_pkg::CMD_SCAN;
      endcase
   end

endmodule

### rtl/core/sdmd_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on sdmd_pkg.

module sdmd_cmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sdmd_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output logic                       head_valid,
   output sdmd_pkg::cmd_type          head_cmd,
   output sdmd_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sdmd_pkg::cmd_type  mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = mem[rd_ptr_ff];
   assign head_valid   = (count_ff != '0);
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

### rtl/core/sdmd_back.sv
// Back end: executes commands on the link, frame, pattern and scan state, drives results.
// Depends on sdmd_pkg and sdmd_rsp_if.

module sdmd_back (
   input  logic              clock,
   input  logic              reset,
   input  sdmd_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  sdmd_pkg::cmd_type head_cmd,
   output logic              pop,
   sdmd_rsp_if.source        rsp_chan
);

   sdmd_pkg::mode_type mode_ff, mode_in;
   logic [7:0]         byte_cnt_ff, byte_cnt_in;
   logic [sdmd_pkg::FRAME_BYTES-1:0][7:0] frame_ff, frame_in;
   logic [15:0]        pattern_ff [sdmd_pkg::GLYPH_ROWS];
   logic [15:0]        pattern_in [sdmd_pkg::GLYPH_ROWS];
   logic [2:0]         scan_row_ff, scan_row_in;
   logic               scan_en_ff, scan_en_in;
   logic               led_ff, led_in;
   logic [11:0]        compare_ff, compare_in;
   logic [7:0]         row_ff, row_in;
   logic [15:0]        column_ff, column_in;
   logic               ready_ff, ready_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               phase_ff, phase_in;
   logic [19:0]        prod_ff, prod_in;

   logic               out_free;
   logic               bright_disp;
   logic [7:0]         cnt_inc;
   logic [20:0]        quo_sum;
   logic [12:0]        quo_est;
   logic [20:0]        quo_back;
   logic [20:0]        quo_rem;
   logic [12:0]        quo;
   logic [13:0]        bright_sum;
   logic [11:0]        bright_val;

   // Draw one glyph row of all five digits, shifted and cut to 16 columns
   function automatic logic [15:0] draw_row(input logic [sdmd_pkg::FRAME_BYTES-1:0][7:0] fb,
                                            input logic [2:0] row);
      logic [19:0] slots;
      logic [39:0] wide;
      logic [14:0] g;
      slots = '0;
      for (int d = 1; d <= 5; d++) begin
         g = (fb[d] < 8'(sdmd_pkg::GLYPH_COUNT)) ? sdmd_pkg::glyph_bits(fb[d][4:0]) : '0;
         slots = {slots[15:0], 1'b0, g[3*row +: 3]};
      end
      wide = {20'd0, slots} << fb[6][4:0];
      return (fb[6] < 8'(sdmd_pkg::SHIFT_LIMIT)) ? wide[19:4] : 16'd0;
   endfunction

   // Divide the registered product by 255: estimate, then one correction step
   assign quo_sum    = {1'b0, prod_ff} + 21'(prod_ff[19:8]) + 21'(prod_ff[19:16]);
   assign quo_est    = quo_sum[20:8];
   assign quo_back   = {quo_est, 8'd0} - 21'(quo_est);
   assign quo_rem    = {1'b0, prod_ff} - quo_back;
   assign quo        = quo_est + 13'(quo_rem >= 21'd255);
   assign bright_sum = 14'(quo) + 14'(cfg.brightness_base);
   assign bright_val = (bright_sum > 14'd4095) ? 12'hFFF : bright_sum[11:0];

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign bright_disp = (head_cmd.kind == sdmd_pkg::CMD_BRIGHT) &&
                        (mode_ff == sdmd_pkg::MODE_DISP);
   assign cnt_inc     = byte_cnt_ff + 8'd1;

   // Execute the head command once the result slot is free
   always_comb begin
      mode_in     = mode_ff;
      byte_cnt_in = byte_cnt_ff;
      frame_in    = frame_ff;
      scan_row_in = scan_row_ff;
      scan_en_in  = scan_en_ff;
      led_in      = led_ff;
      compare_in  = compare_ff;
      row_in      = row_ff;
      column_in   = column_ff;
      ready_in    = ready_ff;
      phase_in    = phase_ff;
      prod_in     = prod_ff;
      pop         = 1'b0;
      for (int r = 0; r < sdmd_pkg::GLYPH_ROWS; r++) begin
         pattern_in[r] = pattern_ff[r];
      end

      if (head_valid) begin
         if (bright_disp && !phase_ff) begin
            // first pass of a display brightness tick: register the product
            phase_in = 1'b1;
            prod_in  = 20'(frame_ff[0]) * 20'(cfg.brightness_span);
         end else if (out_free) begin
            pop      = 1'b1;
            phase_in = 1'b0;
            unique case (head_cmd.kind)
               sdmd_pkg::CMD_RX_ERROR: begin
                  mode_in    = sdmd_pkg::MODE_DISC;
                  scan_en_in = 1'b0;
                  ready_in   = 1'b0;
                  column_in  = '0;
               end
               sdmd_pkg::CMD_RX_BYTE: begin
                  unique case (mode_ff)
                     sdmd_pkg::MODE_DISC: begin
                        byte_cnt_in = head_cmd.zero ? cnt_inc : 8'd0;
                        if (byte_cnt_in >= cfg.handshake_zero_count) begin
                           mode_in     = sdmd_pkg::MODE_HAND;
                           byte_cnt_in = 8'd0;
                           ready_in    = 1'b1;
                        end
                     end
                     sdmd_pkg::MODE_HAND: begin
                        if (!head_cmd.zero) begin
                           frame_in[0] = head_cmd.data;
                           byte_cnt_in = 8'd1;
                           mode_in     = sdmd_pkg::MODE_DISP;
                           led_in      = 1'b1;
                           scan_en_in  = 1'b1;
                        end
                     end
                     default: begin
                        frame_in[byte_cnt_ff[sdmd_pkg::FRAME_IDX_W-1:0]] = head_cmd.data;
                        byte_cnt_in = {5'd0, cnt_inc[sdmd_pkg::FRAME_IDX_W-1:0]};
                     end
                  endcase
               end
               sdmd_pkg::CMD_SCAN: begin
                  if (scan_en_ff) begin
                     if (scan_row_ff < 3'(sdmd_pkg::GLYPH_ROWS)) begin
                        row_in    = ~(8'd1 << scan_row_ff);
                        column_in = pattern_ff[scan_row_ff];
                     end else if (scan_row_ff < 3'(sdmd_pkg::SCAN_ROWS - 1)) begin
                        column_in = '0;
                     end else begin
                        row_in    = sdmd_pkg::RAW_ROW_DRIVE;
                        column_in = {8'd0, frame_ff[7]};
                     end
                     scan_row_in = scan_row_ff + 3'd1;
                  end
               end
               sdmd_pkg::CMD_ROW_OFF: begin
                  if (scan_en_ff) begin
                     column_in = '0;
                  end
               end
               sdmd_pkg::CMD_BRIGHT: begin
                  if (mode_ff == sdmd_pkg::MODE_DISP) begin
                     compare_in = bright_val;
                  end else begin
                     led_in = !led_ff;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase

            // redraw the patterns whenever the event leaves the link displaying
            if (mode_in == sdmd_pkg::MODE_DISP) begin
               for (int r = 0; r < sdmd_pkg::GLYPH_ROWS; r++) begin
                  pattern_in[r] = draw_row(frame_in, 3'(r));
               end
            end
         end
      end

      // hold the result until taken, refill on each executed command
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sdmd_pkg::MODE_DISC;
         byte_cnt_ff  <= '0;
         frame_ff     <= '0;
         scan_row_ff  <= '0;
         scan_en_ff   <= 1'b1;
         led_ff       <= 1'b0;
         compare_ff   <= sdmd_pkg::COMPARE_RESET;
         row_ff       <= sdmd_pkg::ROWS_OFF;
         column_ff    <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         for (int r = 0; r < sdmd_pkg::GLYPH_ROWS; r++) begin
            pattern_ff[r] <= '0;
         end
      end else begin
         mode_ff      <= mode_in;
         byte_cnt_ff  <= byte_cnt_in;
         frame_ff     <= frame_in;
         scan_row_ff  <= scan_row_in;
         scan_en_ff   <= scan_en_in;
         led_ff       <= led_in;
         compare_ff   <= compare_in;
         row_ff       <= row_in;
         column_ff    <= column_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         for (int r = 0; r < sdmd_pkg::GLYPH_ROWS; r++) begin
            pattern_ff[r] <= pattern_in[r];
         end
      end
   end

   // Product register: payload only
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // The output state only moves on a pop, so the result is the state itself
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.row_drive       = row_ff;
   assign rsp_chan.column_drive    = column_ff;
   assign rsp_chan.status_led      = led_ff;
   assign rsp_chan.row_off_compare = compare_ff;
   assign rsp_chan.link_mode       = mode_ff;
   assign rsp_chan.link_ready      = ready_ff;

endmodule

### rtl/core/serial_dot_matrix_display_ctrl.sv
// Serial dot-matrix display controller, top level: front end, command queue, back end, CSRs.
// An accepted event passes the command queue to the back end, which registers its result word;
// while displaying, a brightness tick registers its product before the divide by 255.
// Throughput: one event per cycle while results are taken; such ticks hold the back end.
// Reset: synchronous; queue emptied, link disconnected, rows off, compare 4095, registers
// back to threshold 6, span 550, base 40.

module serial_dot_matrix_display_ctrl #(
   parameter int CMD_QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   sdmd_req_if.sink                          req_chan,
   sdmd_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sdmd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sdmd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sdmd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   sdmd_pkg::cfg_type          cfg;
   sdmd_pkg::queue_status_type q_status;
   sdmd_pkg::cmd_type          push_cmd;
   sdmd_pkg::cmd_type          head_cmd;
   logic                       push;
   logic                       pop;
   logic                       head_valid;

   sdmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdmd_front u_front (
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   sdmd_cmd_queue #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .status     (q_status)
   );

   sdmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

   // Handshake or display mode is only reachable with the ready line raised
   a_link_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.link_mode != sdmd_pkg::MODE_DISC) |-> rsp_chan.link_ready)
      else $error("link left disconnected mode without link_ready");

   // A non-brightness event accepted by an idle block shows its result word
   a_idle_latency: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && q_status.empty && !rsp_chan.valid &&
       req_chan.opcode != sdmd_pkg::OP_BRIGHT) |-> ##2 rsp_chan.valid)
      else $error("result word missing two cycles after an idle accept");

   // The back end only pops when the command queue holds a command
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("back end popped an empty command queue");

endmodule
